FILE: hdl/assert_macros.svh
// assertion helpers shared by hsvf_queue and hsvf_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define HSVF_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// plain invariant checked at every clock edge outside reset
`define HSVF_ASSERT_ALW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

FILE: hdl/hsvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvf_pkg
// Shared types and constants of the HSV first-match color finder.
// ----------------------------------------------------------------------------
package hsvf_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int COORD_W        = 12;
    localparam int OUT_W          = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 3;

    localparam logic [12:0] RST_FRAME_WIDTH = 13'd640;
    localparam logic [7:0]  RST_SAMPLE_STEP = 8'd1;
    localparam logic [7:0]  RST_HUE_LOW     = 8'd35;
    localparam logic [7:0]  RST_HUE_HIGH    = 8'd85;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH = 3'd0,
        REG_SAMPLE_STEP = 3'd1,
        REG_HUE_LOW     = 3'd2,
        REG_HUE_HIGH    = 3'd3,
        REG_SAT_FLOOR   = 3'd4,
        REG_VAL_FLOOR   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [7:0]  sample_step;
        logic [7:0]  hue_low;
        logic [7:0]  hue_high;
        logic [7:0]  sat_floor;
        logic [7:0]  val_floor;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               test;
        logic               last;
    } pix_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_DIV,
        B_CHECK,
        B_EMIT
    } back_state_t;

endpackage

FILE: hdl/hsvf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvf_front
// Raster position tracking and sample-grid marking of incoming pixels.
// ----------------------------------------------------------------------------
module hsvf_front
    import hsvf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pix_valid,
    input  logic        pix_accept,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        frame_end,
    output pix_t        entry
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = (CW + 1 > 13) ? CW + 1 : 13;
    localparam int RCW = RW + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    cph_reg, cph_next;
    logic [7:0]    rph_reg, rph_next;
    logic [WW-1:0] width;
    logic [7:0]    step;

    always_comb
    begin
        step = (cfg.sample_step == 8'd0) ? 8'd1 : cfg.sample_step;
        if (cfg.frame_width == 13'd0)
            width = WW'(1);
        else if (WW'(cfg.frame_width) > WW'(MAX_WIDTH))
            width = WW'(MAX_WIDTH);
        else
            width = WW'(cfg.frame_width);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cph_next = cph_reg;
        rph_next = rph_reg;
        if (pix_accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
                cph_next = '0;
                rph_next = '0;
            end
            else if (WW'(col_reg) + WW'(1) >= width)
            begin
                col_next = '0;
                cph_next = '0;
                row_next = (RCW'(row_reg) + RCW'(1) >= RCW'(MAX_HEIGHT)) ? '0 : row_reg + 1'b1;
                rph_next = ({1'b0, rph_reg} + 9'd1 >= {1'b0, step}) ? 8'd0 : rph_reg + 8'd1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
                cph_next = ({1'b0, cph_reg} + 9'd1 >= {1'b0, step}) ? 8'd0 : cph_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end
    end

    always_comb
    begin
        entry.red   = red;
        entry.green = green;
        entry.blue  = blue;
        entry.col   = COORD_W'(col_reg);
        entry.row   = COORD_W'(row_reg);
        entry.test  = pix_valid && (cph_reg == 8'd0) && (rph_reg == 8'd0);
        entry.last  = frame_end;
    end

endmodule

FILE: hdl/hsvf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvf_queue
// Short word queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hsvf_queue
    import hsvf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pix_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output pix_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    pix_t          mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == NW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    `HSVF_ASSERT_ALW(a_cnt_bound, cnt_reg <= NW'(DEPTH), "queue count above depth")
    `HSVF_ASSERT_IMP(a_ptr_match, cnt_reg == '0, wp_reg == rp_reg, "empty queue with split pointers")

endmodule

FILE: hdl/hsvf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvf_back
// HSV conversion with bit-serial division, window test and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hsvf_back
    import hsvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_not_empty,
    input  pix_t              q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tuser,
    output logic [OUT_W-1:0]  m_x,
    output logic [OUT_W-1:0]  m_y
);

    back_state_t state_reg, state_next;
    pix_t        item_reg;
    logic        seen_reg;
    logic [COORD_W-1:0] mcol_reg, mrow_reg;
    logic [7:0]  mx_reg, hden_reg;
    logic        dz_reg, mz_reg;
    logic [7:0]  hrem_reg, srem_reg, hlo_reg, slo_reg, hq_reg, sq_reg;
    logic [2:0]  cnt_reg;
    logic        ov_reg, of_reg;
    logic [OUT_W-1:0] ox_reg, oy_reg;

    logic [7:0]  mx, mn, d;
    logic [15:0] hnum, snum;
    logic [8:0]  htry, stry;
    logic [7:0]  h, s;
    logic        hue_ok, hit, out_free;

    always_comb
    begin
        mx = item_reg.red;
        mn = item_reg.red;
        if (item_reg.green > mx) mx = item_reg.green;
        if (item_reg.blue > mx)  mx = item_reg.blue;
        if (item_reg.green < mn) mn = item_reg.green;
        if (item_reg.blue < mn)  mn = item_reg.blue;
        d = mx - mn;
        snum = 16'(d) * 16'd255;
        if (item_reg.red == mx)
        begin
            if (item_reg.green >= item_reg.blue)
                hnum = 16'd30 * 16'(item_reg.green - item_reg.blue);
            else
                hnum = 16'd180 * 16'(d) - 16'd30 * 16'(item_reg.blue - item_reg.green);
        end
        else if (item_reg.green == mx)
            hnum = 16'd60 * 16'(d) + 16'd30 * 16'(item_reg.blue) - 16'd30 * 16'(item_reg.red);
        else
            hnum = 16'd120 * 16'(d) + 16'd30 * 16'(item_reg.red) - 16'd30 * 16'(item_reg.green);
    end

    assign htry = {hrem_reg, hlo_reg[7]} - {1'b0, hden_reg};
    assign stry = {srem_reg, slo_reg[7]} - {1'b0, mx_reg};

    always_comb
    begin
        h = dz_reg ? 8'd0 : hq_reg;
        s = mz_reg ? 8'd0 : sq_reg;
        if (cfg.hue_low <= cfg.hue_high)
            hue_ok = (h >= cfg.hue_low) && (h <= cfg.hue_high);
        else
            hue_ok = (h >= cfg.hue_low) || (h <= cfg.hue_high);
        hit = hue_ok && (s >= cfg.sat_floor) && (mx_reg >= cfg.val_floor);
    end

    assign out_free = !ov_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.test && !seen_reg)
                        state_next = B_PREP;
                    else if (q_data.last)
                        state_next = B_EMIT;
                end
            end
            B_PREP:  state_next = B_DIV;
            B_DIV:   state_next = (cnt_reg == 3'd7) ? B_CHECK : B_DIV;
            B_CHECK: state_next = item_reg.last ? B_EMIT : B_IDLE;
            B_EMIT:  state_next = out_free ? B_IDLE : B_EMIT;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            seen_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_PREP)
                cnt_reg <= '0;
            else if (state_reg == B_DIV)
                cnt_reg <= cnt_reg + 3'd1;
            if (state_reg == B_CHECK && hit)
                seen_reg <= 1'b1;
            if (state_reg == B_EMIT && out_free)
            begin
                ov_reg   <= 1'b1;
                seen_reg <= 1'b0;
            end
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_data;
        if (state_reg == B_PREP)
        begin
            mx_reg   <= mx;
            hden_reg <= d;
            dz_reg   <= (d == 8'd0);
            mz_reg   <= (mx == 8'd0);
            hrem_reg <= hnum[15:8];
            hlo_reg  <= hnum[7:0];
            srem_reg <= snum[15:8];
            slo_reg  <= snum[7:0];
        end
        else if (state_reg == B_DIV)
        begin
            hlo_reg  <= {hlo_reg[6:0], 1'b0};
            slo_reg  <= {slo_reg[6:0], 1'b0};
            hrem_reg <= htry[8] ? {hrem_reg[6:0], hlo_reg[7]} : htry[7:0];
            srem_reg <= stry[8] ? {srem_reg[6:0], slo_reg[7]} : stry[7:0];
            hq_reg   <= {hq_reg[6:0], !htry[8]};
            sq_reg   <= {sq_reg[6:0], !stry[8]};
        end
        if (state_reg == B_CHECK && hit)
        begin
            mcol_reg <= item_reg.col;
            mrow_reg <= item_reg.row;
        end
        if (state_reg == B_EMIT && out_free)
        begin
            of_reg <= seen_reg;
            ox_reg <= seen_reg ? {1'b0, mcol_reg} : '1;
            oy_reg <= seen_reg ? {1'b0, mrow_reg} : '1;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = of_reg;
    assign m_x      = ox_reg;
    assign m_y      = oy_reg;

    `HSVF_ASSERT_IMP(a_pop_idle, q_pop, state_reg == B_IDLE, "queue popped outside idle")
    `HSVF_ASSERT_IMP(a_miss_coord, ov_reg && !of_reg, (ox_reg == '1) && (oy_reg == '1),
        "miss result without minus one coordinates")

endmodule

FILE: hdl/hsv_color_first_match_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_first_match_finder_unit
// Finds the first pixel of a frame whose HSV color falls in a window.
// ----------------------------------------------------------------------------
// channel | dir | words
// s_*     | in  | pixels: tdata red,green,blue; tlast frame end
// m_*     | out | one result per frame: tdata hit_x,hit_y; tuser hit_found
// cfg_*   | in  | register writes, always ready
// A pixel off the sample grid, or after a match, is popped without a test.
// A tested pixel goes through load, prepare, 8 divider steps and check.
// A frame end then loads the result register once the output is free.
// The front counts positions and feeds a 4-word queue; input stalls when full.
// Reset is asynchronous; it clears counters, queue and match and loads register defaults.
// ----------------------------------------------------------------------------
module hsv_color_first_match_finder_unit
    import hsvf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red, green, blue
    input  logic                  s_tlast,   // frame_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // hit_x, hit_y, zero pad
    output logic                  m_tuser,   // hit_found
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    pix_t       entry, q_data;
    logic       q_full, q_not_empty, q_pop, push;
    logic [OUT_W-1:0] hx, hy;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width <= RST_FRAME_WIDTH;
            cfg_reg.sample_step <= RST_SAMPLE_STEP;
            cfg_reg.hue_low     <= RST_HUE_LOW;
            cfg_reg.hue_high    <= RST_HUE_HIGH;
            cfg_reg.sat_floor   <= '0;
            cfg_reg.val_floor   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH: cfg_reg.frame_width <= cfg_data;
                REG_SAMPLE_STEP: cfg_reg.sample_step <= cfg_data[7:0];
                REG_HUE_LOW:     cfg_reg.hue_low     <= cfg_data[7:0];
                REG_HUE_HIGH:    cfg_reg.hue_high    <= cfg_data[7:0];
                REG_SAT_FLOOR:   cfg_reg.sat_floor   <= cfg_data[7:0];
                REG_VAL_FLOOR:   cfg_reg.val_floor   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    hsvf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix_valid  (s_tvalid),
        .pix_accept (push),
        .red        (s_tdata[7:0]),
        .green      (s_tdata[15:8]),
        .blue       (s_tdata[23:16]),
        .frame_end  (s_tlast),
        .entry      (entry)
    );

    hsvf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    hsvf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_x         (hx),
        .m_y         (hy)
    );

    assign m_tdata = {6'd0, hy, hx};

endmodule

FILE: tb/hsv_color_first_match_finder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_first_match_finder_unit_tb
// Streams RGB frames through the finder under several register settings, with
// random gaps on both sides and one long output hold-off, and compares every
// frame result against an in-bench HSV first-match predictor.
// ----------------------------------------------------------------------------
module hsv_color_first_match_finder_unit_tb;
    import hsvf_pkg::*;

    typedef struct packed {
        logic        found;
        logic [12:0] x;
        logic [12:0] y;
    } hit_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hit_t        hit_queue[$];
    int          error_count;
    int          hit_count;
    int          found_count;
    int          pixel_count;
    int          cycle_count;
    int          hold_cycles;
    int          rx_wait;
    logic [12:0] frame_width_q;
    logic [7:0]  step_q, hue_low_q, hue_high_q, sat_floor_q, val_floor_q;
    int          col_q, row_q, col_ph, row_ph;
    logic        seen_q;
    int          match_col_q, match_row_q;

    hsv_color_first_match_finder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[hsv_color_first_match_finder_unit] ERROR");
            $finish;
        end
    end

    function automatic int hue_of(int r, int g, int b, int mx, int d);
        if (d == 0)
            return 0;
        if (r == mx)
            return (g >= b) ? (30 * (g - b)) / d : (180 * d - 30 * (b - g)) / d;
        if (g == mx)
            return (60 * d + 30 * b - 30 * r) / d;
        return (120 * d + 30 * r - 30 * g) / d;
    endfunction

    task automatic clear_frame_state();
        col_q = 0;
        row_q = 0;
        col_ph = 0;
        row_ph = 0;
        seen_q = 1'b0;
        match_col_q = 0;
        match_row_q = 0;
    endtask

    task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        int   stp, wid, mx, mn, d, h, s;
        logic hue_ok;
        hit_t hit;
        stp = (step_q == 0) ? 1 : step_q;
        wid = (frame_width_q == 0) ? 1 : frame_width_q;
        if (wid > 4096)
            wid = 4096;
        if (!seen_q && col_ph == 0 && row_ph == 0)
        begin
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            h = hue_of(r, g, b, mx, d);
            s = (mx == 0) ? 0 : (255 * d) / mx;
            hue_ok = (hue_low_q <= hue_high_q) ? (h >= hue_low_q && h <= hue_high_q)
                                                 : (h >= hue_low_q || h <= hue_high_q);
            if (hue_ok && s >= sat_floor_q && mx >= val_floor_q)
            begin
                seen_q = 1'b1;
                match_col_q = col_q;
                match_row_q = row_q;
            end
        end
        if (last)
        begin
            hit.found = seen_q;
            hit.x = seen_q ? 13'(match_col_q) : 13'h1FFF;
            hit.y = seen_q ? 13'(match_row_q) : 13'h1FFF;
            hit_queue.push_back(hit);
            clear_frame_state();
        end
        else if (col_q + 1 >= wid)
        begin
            col_q = 0;
            col_ph = 0;
            row_q = (row_q + 1 >= 4096) ? 0 : row_q + 1;
            row_ph = (row_ph + 1 >= stp) ? 0 : row_ph + 1;
        end
        else
        begin
            col_q++;
            col_ph = (col_ph + 1 >= stp) ? 0 : col_ph + 1;
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hit_queue.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = hit_queue.pop_front();
                hit_count++;
                if (want.found)
                    found_count++;
                if (m_tuser !== want.found)
                    report_mismatch("hit_found", m_tuser, want.found);
                if (m_tdata[12:0] !== want.x)
                    report_mismatch("hit_x", m_tdata[12:0], want.x);
                if (m_tdata[25:13] !== want.y)
                    report_mismatch("hit_y", m_tdata[25:13], want.y);
                if (m_tdata[31:26] !== 6'd0)
                    report_mismatch("pad", m_tdata[31:26], 0);
            end
        end
    end

    // receiver: random wait per word, or a long hold-off when requested
    always @(posedge clk)
    begin
        int draw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            draw = $urandom_range(11);
            rx_wait  <= draw;
            m_tready <= (draw == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(cfg_reg_t idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: frame_width_q = value;
            REG_SAMPLE_STEP: step_q = value[7:0];
            REG_HUE_LOW:     hue_low_q = value[7:0];
            REG_HUE_HIGH:    hue_high_q = value[7:0];
            REG_SAT_FLOOR:   sat_floor_q = value[7:0];
            REG_VAL_FLOOR:   val_floor_q = value[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (hit_queue.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic setup_regs(logic [12:0] w, logic [7:0] st, logic [7:0] lo,
                              logic [7:0] hi, logic [7:0] sf, logic [7:0] vf);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_SAMPLE_STEP, 13'(st));
        write_reg(REG_HUE_LOW, 13'(lo));
        write_reg(REG_HUE_HIGH, 13'(hi));
        write_reg(REG_SAT_FLOOR, 13'(sf));
        write_reg(REG_VAL_FLOOR, 13'(vf));
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic last, bit gaps);
        int idle;
        idle = gaps ? (($urandom_range(2) == 0) ? 0 : $urandom_range(11)) : 0;
        repeat (idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel(r, g, b, last);
        pixel_count++;
    endtask

    task automatic random_frame(int npix, bit gaps);
        logic [7:0] r, g, b;
        for (int i = 0; i < npix; i++)
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            if ($urandom_range(4) == 0)
            begin
                r = {8{r[0]}};
                g = r;
            end
            send_pixel(r, g, b, i == npix - 1, gaps);
        end
    endtask

    task automatic test_directed();
        setup_regs(13'd4, 8'd1, 8'd0, 8'd179, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
        setup_regs(13'd4, 8'd1, 8'd0, 8'd10, 8'd200, 8'd200);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
        setup_regs(13'd3, 8'd1, 8'd170, 8'd10, 8'd1, 8'd1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd1, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1, 1'b1);
        setup_regs(13'd0, 8'd0, 8'd60, 8'd60, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1, 1'b1);
        setup_regs(13'h1FFF, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd64, 8'd200, 1'b1, 1'b1);
        setup_regs(13'd2, 8'd2, 8'd0, 8'd255, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd127, 1'b0, 1'b1);
        send_pixel(8'd10, 8'd20, 8'd30, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_step_change();
        setup_regs(13'd5, 8'd3, 8'd0, 8'd179, 8'd0, 8'd255);
        repeat (7) send_pixel(8'd1, 8'd2, 8'd3, 1'b0, 1'b1);
        drain();
        write_reg(REG_SAMPLE_STEP, 13'd1);
        write_reg(REG_VAL_FLOOR, 13'd0);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b0, 1'b1);
        send_pixel(8'd9, 8'd9, 8'd9, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_random_settings();
        logic [12:0] w;
        logic [7:0]  st;
        for (int p = 0; p < 12; p++)
        begin
            w  = ($urandom_range(5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 12));
            st = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            setup_regs(w, st, 8'($urandom_range(0, 190)), 8'($urandom_range(0, 190)),
                       8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)));
            for (int f = 0; f < 8; f++)
                random_frame($urandom_range(1, 12), 1'b1);
            drain();
        end
    endtask

    task automatic test_backpressure();
        setup_regs(13'd2, 8'd1, 8'd200, 8'd0, 8'd0, 8'd0);
        hold_cycles = 600;
        for (int f = 0; f < 20; f++)
            random_frame($urandom_range(1, 4), 1'b0);
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        hold_cycles = 0;
        error_count = 0;
        hit_count = 0;
        found_count = 0;
        pixel_count = 0;
        cycle_count = 0;
        frame_width_q = RST_FRAME_WIDTH;
        step_q = RST_SAMPLE_STEP;
        hue_low_q = RST_HUE_LOW;
        hue_high_q = RST_HUE_HIGH;
        sat_floor_q = 8'd0;
        val_floor_q = 8'd0;
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        random_frame(6, 1'b1);
        drain();
        test_directed();
        test_step_change();
        test_random_settings();
        test_backpressure();
        drain();
        $display("run covered %0d pixels and %0d frame results, %0d with a hit",
                 pixel_count, hit_count, found_count);
        if (error_count == 0 && hit_queue.size() == 0)
            $display("[hsv_color_first_match_finder_unit] OK");
        else
            $display("[hsv_color_first_match_finder_unit] ERROR");
        $finish;
    end
endmodule

FILE: hsv_color_first_match_finder_unit.f
+incdir+hdl
hdl/hsvf_pkg.sv
hdl/hsvf_front.sv
hdl/hsvf_queue.sv
hdl/hsvf_back.sv
hdl/hsv_color_first_match_finder_unit.sv
tb/hsv_color_first_match_finder_unit_tb.sv
